// File: design/idf_pkg.sv
// ----------------------------------------------------------------------------
// idf_pkg: shared types and constants for the IMU frame deframer
// Transfer structs for the byte and frame channels, frame layout constants
// and the status group from the control cell to the top level.
// ----------------------------------------------------------------------------
package idf_pkg;

    localparam int          WIN_LEN     = 21;
    localparam int          PAYLOAD_LEN = 20;
    localparam int          WORD_COUNT  = PAYLOAD_LEN / 2;
    localparam int          FILL_W      = $clog2(WIN_LEN + 1);
    localparam logic [7:0]  HEADER_BYTE = 8'hFF;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [63:0] byte_time;
    } byte_item_t;

    typedef struct packed {
        logic [63:0]        frame_time;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_rate;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] temperature_raw;
        logic [15:0]        sensor_time;
    } frame_item_t;

    typedef struct packed {
        logic full;
        logic frame_hit;
    } ctrl_status_t;

endpackage

// File: design/imu_frame_deframer.sv
// ----------------------------------------------------------------------------
// imu_frame_deframer: IMU serial frame finder
// Sliding 21-cell byte window with a running checksum; emits one decoded
// frame for each good 0xFF-headed 22-byte frame in the byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while not stalled, with no gaps of its own:
// each accepted byte shifts a chain of 21 cells one place, and the header and
// checksum test for the oldest cell is made in that same cycle against a
// running modulo-256 sum that is updated by one add and one subtract. A frame
// is presented on the frame channel from an output register in the cycle after
// its checksum byte is accepted. The byte channel stalls only when that output
// register is full and its own transfer is stalled, so the stream halts while a
// finished frame waits. A failed candidate drops only its header; after a good
// frame the next 21 bytes are passed without a test.
// Timestamps are kept at TIME_BITS bits and zero-extended on output.
// ----------------------------------------------------------------------------
module imu_frame_deframer #(
    parameter int TIME_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  idf_pkg::byte_item_t  byte_item,
    output logic                 frame_valid,
    input  logic                 frame_stall,
    output idf_pkg::frame_item_t frame_item
);
    import idf_pkg::*;

    logic                 accept;
    logic [7:0]           win_byte [0:WIN_LEN];
    logic [TIME_BITS-1:0] win_time [0:WIN_LEN];
    logic [15:0]          word [0:WORD_COUNT-1];
    ctrl_status_t         status;
    logic                 frame_valid_reg, frame_valid_next;
    frame_item_t          frame_item_reg;

    // Transfer a byte whenever the output register is free or being emptied.
    assign byte_stall = frame_valid_reg && frame_stall;
    assign accept     = byte_valid && !byte_stall;

    // Slot WIN_LEN is the arriving byte; slot 0 is the oldest (header) cell.
    assign win_byte[WIN_LEN] = byte_item.byte_value;
    assign win_time[WIN_LEN] = byte_item.byte_time[TIME_BITS-1:0];

    for (genvar i = 0; i < WIN_LEN; i++)
    begin : g_cell
        idf_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .clk     (clk),
            .shift   (accept),
            .byte_in (win_byte[i+1]),
            .time_in (win_time[i+1]),
            .byte_out(win_byte[i]),
            .time_out(win_time[i])
        );
    end

    idf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (accept),
        .head_byte (win_byte[0]),
        .leave_byte(win_byte[1]),
        .new_byte  (win_byte[WIN_LEN]),
        .status    (status)
    );

    // Big-endian words from the payload cells.
    for (genvar w = 0; w < WORD_COUNT; w++)
    begin : g_word
        assign word[w] = {win_byte[1 + 2*w], win_byte[2 + 2*w]};
    end

    // Load on a hit, drop after the frame transfer, otherwise hold.
    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        if (accept && status.frame_hit)
            frame_valid_next = 1'b1;
        else if (!frame_stall)
            frame_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_valid_reg <= 1'b0;
        else
            frame_valid_reg <= frame_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && status.frame_hit)
        begin
            frame_item_reg.frame_time      <= 64'(win_time[0]);
            frame_item_reg.roll_angle      <= word[0];
            frame_item_reg.pitch_angle     <= word[1];
            frame_item_reg.roll_rate       <= word[2];
            frame_item_reg.pitch_rate      <= word[3];
            frame_item_reg.yaw_rate        <= word[4];
            frame_item_reg.accel_x         <= word[5];
            frame_item_reg.accel_y         <= word[6];
            frame_item_reg.accel_z         <= word[7];
            frame_item_reg.temperature_raw <= word[8];
            frame_item_reg.sensor_time     <= word[9];
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame_item  = frame_item_reg;

    a_hit_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.frame_hit |-> status.full)
        else $error("frame hit before window filled");

    a_hit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.frame_hit |=> frame_valid)
        else $error("accepted frame not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |-> !accept)
        else $error("byte transfer while a stalled frame is held");

endmodule

// File: design/idf_cell.sv
// ----------------------------------------------------------------------------
// idf_cell: one window position of the deframer
// Holds one byte and its timestamp; loads from its younger neighbor on shift.
// ----------------------------------------------------------------------------
module idf_cell #(
    parameter int TIME_BITS = 64
) (
    input  logic                 clk,
    input  logic                 shift,
    input  logic [7:0]           byte_in,
    input  logic [TIME_BITS-1:0] time_in,
    output logic [7:0]           byte_out,
    output logic [TIME_BITS-1:0] time_out
);

    logic [7:0]           byte_reg;
    logic [TIME_BITS-1:0] time_reg;

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
            time_reg <= time_in;
        end
    end

    assign byte_out = byte_reg;
    assign time_out = time_reg;

endmodule

// File: design/idf_ctrl.sv
// ----------------------------------------------------------------------------
// idf_ctrl: fill count, skip count and running checksum
// Decides once per arriving byte whether the oldest window byte heads a
// good frame.
// ----------------------------------------------------------------------------
module idf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic [7:0]           head_byte,
    input  logic [7:0]           leave_byte,
    input  logic [7:0]           new_byte,
    output idf_pkg::ctrl_status_t status
);
    import idf_pkg::*;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] skip_reg, skip_next;
    logic [7:0]        sum_reg, sum_next;
    logic              full;
    logic              hit;

    assign full = (fill_reg == FILL_W'(WIN_LEN));
    assign hit  = full && (skip_reg == '0) && (head_byte == HEADER_BYTE)
                  && (sum_reg == new_byte);

    assign status.full      = full;
    assign status.frame_hit = hit;

    always_comb
    begin
        fill_next = fill_reg;
        skip_next = skip_reg;
        sum_next  = sum_reg;
        if (shift)
        begin
            // sum covers the 20 positions after the header
            sum_next = sum_reg + new_byte
                       - ((fill_reg >= FILL_W'(WIN_LEN - 1)) ? leave_byte : 8'd0);
            if (!full)
                fill_next = fill_reg + 1'b1;
            else if (skip_reg != '0)
                skip_next = skip_reg - 1'b1;
            else if (hit)
                skip_next = FILL_W'(WIN_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            skip_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            skip_reg <= skip_next;
            sum_reg  <= sum_next;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WIN_LEN))
        else $error("fill count beyond window length");

    a_skip_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg != '0 |-> full)
        else $error("skip count set before window filled");

    a_hit_arms_skip: assert property (@(posedge clk) disable iff (!rst_n)
        shift && hit |=> skip_reg == FILL_W'(WIN_LEN))
        else $error("accepted frame did not arm skip count");

    a_skip_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        shift && skip_reg != '0 |=> skip_reg == $past(skip_reg) - 1'b1)
        else $error("skip count did not advance");

endmodule
